[rtl/core/matrix_vector_transform_4x4_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 matrix-vector transform
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_MACROS_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_MACROS_SVH

// Same-cycle implication
`define MVT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MVT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Invariant
`define MVT_ASSERT_ALW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

[rtl/core/mvt_pkg.sv]
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the 4x4 matrix-vector transform.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int COEF_W        = 32;
  localparam int NUM_ROWS      = 4;
  localparam int NUM_COLS      = 4;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = 3;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int PROD_W        = 2 * COEF_W;
  localparam int PAIR_W        = PROD_W + 1;
  localparam int SUM_W         = PROD_W + 2;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [COEF_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] Q_MIN = 32'h8000_0000;

  // Reset matrix (row-major, two coefficients per register): 0x10000 on the diagonal of rows 1-3, 1 at row 0 col 1
  localparam logic [CFG_DATA_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0001_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  typedef logic [NUM_COLS-1:0][COEF_W-1:0] coef_row_t;
  typedef coef_row_t [NUM_ROWS-1:0]        coef_mat_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] vec_w;
    logic signed [COEF_W-1:0] vec_z;
    logic signed [COEF_W-1:0] vec_y;
    logic signed [COEF_W-1:0] vec_x;
  } mvt_vec_t;

  typedef struct packed {
    logic                     clipped;
    logic signed [COEF_W-1:0] out_w;
    logic signed [COEF_W-1:0] out_z;
    logic signed [COEF_W-1:0] out_y;
    logic signed [COEF_W-1:0] out_x;
  } mvt_res_t;

  // Lane to merge stage
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } lane_out_t;

endpackage

[rtl/core/mvt_if.sv]
// ----------------------------------------------------------------------------
// mvt channel interfaces
// Valid/ready channels for the vector input, the result output and the
// configuration writes.
// ----------------------------------------------------------------------------
interface mvt_vec_if import mvt_pkg::*; ();
  logic     valid;
  logic     ready;
  mvt_vec_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mvt_res_if import mvt_pkg::*; ();
  logic     valid;
  logic     ready;
  mvt_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mvt_cfg_if import mvt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/core/mvt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mvt_cfg_regs
// Coefficient register file; unpacks the eight 64-bit words into the matrix.
// ----------------------------------------------------------------------------
module mvt_cfg_regs import mvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvt_cfg_if.sink    cfg_i,
  output coef_mat_t  coef_o
);

  logic [CFG_DATA_W-1:0] regs_q [NUM_REGS];

  assign cfg_i.ready = 1'b1;

  // Out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= CFG_RESET[i];
      end
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_W'(NUM_REGS))) begin
      regs_q[cfg_i.index[REG_IDX_W-1:0]] <= cfg_i.wdata;
    end
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      if (c % 2 == 1) begin : g_hi
        assign coef_o[r][c] = regs_q[2 * r + c / 2][CFG_DATA_W-1:COEF_W];
      end else begin : g_lo
        assign coef_o[r][c] = regs_q[2 * r + c / 2][COEF_W-1:0];
      end
    end
  end

endmodule

[rtl/core/mvt_lane.sv]
// ----------------------------------------------------------------------------
// mvt_lane
// One matrix row: four products, pair sums, full-width total. Three stages.
// ----------------------------------------------------------------------------
`include "matrix_vector_transform_4x4_macros.svh"

module mvt_lane import mvt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  coef_row_t coef_i,
  input  coef_row_t vec_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output lane_out_t lane_o,
  input  logic      out_ready_i
);

  logic signed [PROD_W-1:0] prod_d [NUM_COLS];
  logic signed [PROD_W-1:0] prod_q [NUM_COLS];
  logic signed [PAIR_W-1:0] pair_q [2];
  logic signed [SUM_W-1:0]  sum_q;
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // Each stage moves when it is empty or its successor takes its word
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  for (genvar c = 0; c < NUM_COLS; c++) begin : g_mul
    assign prod_d[c] = $signed(coef_i[c]) * $signed(vec_i[c]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        prod_q[c] <= prod_d[c];
      end
    end
    if (rdy2 && v1_q) begin
      pair_q[0] <= PAIR_W'(prod_q[0]) + PAIR_W'(prod_q[1]);
      pair_q[1] <= PAIR_W'(prod_q[2]) + PAIR_W'(prod_q[3]);
    end
    if (rdy3 && v2_q) begin
      sum_q <= SUM_W'(pair_q[0]) + SUM_W'(pair_q[1]);
    end
  end

  assign lane_o.valid = v3_q;
  assign lane_o.sum   = sum_q;

  `MVT_ASSERT_NXT(a_lane_accept_fills, in_valid_i && in_ready_o, v1_q, "accepted word lost")
  `MVT_ASSERT_NXT(a_lane_stall_holds, v3_q && !out_ready_i, v3_q && $stable(sum_q), "sum changed while stalled")

endmodule

[rtl/core/mvt_merge.sv]
// ----------------------------------------------------------------------------
// mvt_merge
// Scales the four row sums, saturates them, ORs the clip flags and holds
// the result word in the output register.
// ----------------------------------------------------------------------------
`include "matrix_vector_transform_4x4_macros.svh"

module mvt_merge import mvt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_out_t lane_i [NUM_ROWS],
  output logic      lane_ready_o,
  mvt_res_if.source res_o
);

  logic [NUM_ROWS-1:0]   lane_valid;
  logic [COEF_W-1:0]     sat   [NUM_ROWS];
  logic [NUM_ROWS-1:0]   clip;
  logic [NUM_ROWS-1:0]   at_rail;
  mvt_res_t              res_d, res_q;
  logic                  res_valid_q;

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_sat
    logic signed [SUM_W-1:0]     shifted;
    logic [SUM_W-COEF_W:0]       hi_bits;

    // Arithmetic shift floors toward minus infinity
    assign shifted       = $signed(lane_i[r].sum) >>> FRAC_BITS;
    assign hi_bits       = shifted[SUM_W-1:COEF_W-1];
    assign clip[r]       = !((&hi_bits) || !(|hi_bits));
    assign sat[r]        = !clip[r] ? shifted[COEF_W-1:0] :
                           (shifted[SUM_W-1] ? Q_MIN : Q_MAX);
    assign lane_valid[r] = lane_i[r].valid;
  end

  assign lane_ready_o = !res_valid_q || res_o.ready;

  always_comb begin
    res_d.out_x   = sat[0];
    res_d.out_y   = sat[1];
    res_d.out_z   = sat[2];
    res_d.out_w   = sat[3];
    res_d.clipped = |clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (lane_ready_o) begin
      res_valid_q <= &lane_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_ready_o && (&lane_valid)) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  assign at_rail[0] = (res_q.out_x == Q_MAX) || (res_q.out_x == Q_MIN);
  assign at_rail[1] = (res_q.out_y == Q_MAX) || (res_q.out_y == Q_MIN);
  assign at_rail[2] = (res_q.out_z == Q_MAX) || (res_q.out_z == Q_MIN);
  assign at_rail[3] = (res_q.out_w == Q_MAX) || (res_q.out_w == Q_MIN);

  `MVT_ASSERT_IMP(a_merge_clip_on_rail, res_valid_q && res_q.clipped, at_rail != '0, "clip flag without saturated element")

endmodule

[rtl/core/matrix_vector_transform_4x4.sv]
// Transforms one 4-element Q(32-FRAC_BITS).FRAC_BITS vector per word by the 4x4
// matrix held in eight 64-bit coefficient registers. A new vector is accepted
// every clock unless the result port stalls the lanes; each result passes through three
// stages in each of the four row lanes (multiply, pair add, total add) and then the
// scale-and-saturate output register. Back-pressure on the result port stalls
// the lanes stage by stage, so empty stages keep filling. Configuration writes
// are always ready and must only be issued while no vector is in flight.
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4
// Top level: coefficient registers, four row lanes and the merge stage.
// ----------------------------------------------------------------------------
`include "matrix_vector_transform_4x4_macros.svh"

module matrix_vector_transform_4x4 import mvt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mvt_cfg_if.sink   cfg_i,
  mvt_vec_if.sink   vec_i,
  mvt_res_if.source res_o
);

  coef_mat_t           coef;
  coef_row_t           vec_arr;
  lane_out_t           lane_out [NUM_ROWS];
  logic [NUM_ROWS-1:0] lane_in_ready;
  logic [NUM_ROWS-1:0] lane_valid;
  logic                merge_ready;

  assign vec_arr[0] = vec_i.data.vec_x;
  assign vec_arr[1] = vec_i.data.vec_y;
  assign vec_arr[2] = vec_i.data.vec_z;
  assign vec_arr[3] = vec_i.data.vec_w;

  mvt_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef)
  );

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    mvt_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .coef_i      (coef[r]),
      .vec_i       (vec_arr),
      .in_valid_i  (vec_i.valid),
      .in_ready_o  (lane_in_ready[r]),
      .lane_o      (lane_out[r]),
      .out_ready_i (merge_ready)
    );
    assign lane_valid[r] = lane_out[r].valid;
  end

  // Lanes run in lockstep; any one of them speaks for all
  assign vec_i.ready = lane_in_ready[0];

  mvt_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lane_i       (lane_out),
    .lane_ready_o (merge_ready),
    .res_o        (res_o)
  );

  `MVT_ASSERT_ALW(a_top_lanes_lockstep, ((&lane_valid) || !(|lane_valid)) && ((&lane_in_ready) || !(|lane_in_ready)), "row lanes out of step")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the 4x4 matrix-vector transform. Loads coefficient matrices
// through the config channel, streams vectors with random source gaps and
// sink stalls, and checks each result word against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
  import mvt_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_REPORTS = 10;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  typedef logic [CFG_DATA_W-1:0] reg_image_t [NUM_REGS];

  logic clk_i;
  logic rst_ni;

  mvt_cfg_if cfg_bus ();
  mvt_vec_if vec_bus ();
  mvt_res_if res_bus ();

  matrix_vector_transform_4x4 #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .vec_i (vec_bus),
    .res_o (res_bus)
  );

  reg_image_t matrix_regs;
  mvt_res_t   transformed_vectors[$];
  int         n_mismatch = 0;
  int         idle_cycles = 0;
  bit         no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fixed-point transform: exact 66-bit row sums, floor shift, saturate.
  function automatic mvt_res_t transform_vector(mvt_vec_t v);
    logic signed [COEF_W-1:0] elem [NUM_COLS];
    logic signed [COEF_W-1:0] lane [NUM_ROWS];
    logic signed [COEF_W-1:0] coef;
    logic signed [65:0]       acc, op_c, op_v, scaled;
    logic [CFG_DATA_W-1:0]    r;
    mvt_res_t                 res;
    elem[0] = v.vec_x;
    elem[1] = v.vec_y;
    elem[2] = v.vec_z;
    elem[3] = v.vec_w;
    res.clipped = 1'b0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      acc = '0;
      for (int j = 0; j < NUM_COLS; j++) begin
        r    = matrix_regs[i * 2 + j / 2];
        coef = (j % 2) ? r[63:32] : r[31:0];
        op_c = coef;
        op_v = elem[j];
        acc  = acc + op_c * op_v;
      end
      scaled = acc >>> FRAC;
      if (scaled > SAT_HI) begin
        lane[i] = Q_MAX;
        res.clipped = 1'b1;
      end else if (scaled < SAT_LO) begin
        lane[i] = Q_MIN;
        res.clipped = 1'b1;
      end else begin
        lane[i] = scaled[COEF_W-1:0];
      end
    end
    res.out_x = lane[0];
    res.out_y = lane[1];
    res.out_z = lane[2];
    res.out_w = lane[3];
    return res;
  endfunction

  function automatic mvt_vec_t make_vec(logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic [31:0] w);
    mvt_vec_t v;
    v.vec_x = x;
    v.vec_y = y;
    v.vec_z = z;
    v.vec_w = w;
    return v;
  endfunction

  // diag on the main diagonal, off everywhere else
  function automatic reg_image_t uniform_matrix(logic [31:0] diag, logic [31:0] off);
    reg_image_t m;
    for (int i = 0; i < NUM_ROWS; i++) begin
      m[i * 2]     = {(i == 1) ? diag : off, (i == 0) ? diag : off};
      m[i * 2 + 1] = {(i == 3) ? diag : off, (i == 2) ? diag : off};
    end
    return m;
  endfunction

  function automatic logic [31:0] extreme_q();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [31:0] small_q(int lim);
    return 32'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  // mostly moderate coefficients, so that results clip only now and then
  function automatic logic [31:0] random_coef();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) return small_q(1 << 18);
    if (pick <= 7) return $urandom;
    if (pick == 8) return extreme_q();
    return '0;
  endfunction

  function automatic logic [31:0] random_elem();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) return small_q(1 << 24);
    if (pick <= 8) return $urandom;
    return extreme_q();
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Called at a falling edge; returns at the falling edge after the handshake.
  // valid is left high so back-to-back words never toggle it within one step.
  task automatic send_vec(mvt_vec_t v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      vec_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    vec_bus.valid <= 1'b1;
    vec_bus.data  <= v;
    do @(posedge clk_i); while (!vec_bus.ready);
    transformed_vectors.push_back(transform_vector(v));
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.wdata <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx < NUM_REGS)
      matrix_regs[idx[REG_IDX_W-1:0]] = val;
    @(negedge clk_i);
  endtask

  task automatic load_matrix(reg_image_t m);
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(CFG_IDX_W'(i), m[i]);
    cfg_bus.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait for all words in flight, then leave a pipeline margin.
  task automatic drain_vectors();
    vec_bus.valid <= 1'b0;
    while (transformed_vectors.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic test_reset_matrix();
    send_vec(make_vec(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000));
    send_vec(make_vec($urandom, $urandom, $urandom, $urandom));
    send_vec(make_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    drain_vectors();
  endtask

  task automatic test_saturation();
    // 4 * 2^62 exceeds 64 bits before the shift
    load_matrix(uniform_matrix(32'h8000_0000, 32'h8000_0000));
    send_vec(make_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_vec(make_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    drain_vectors();
    load_matrix(uniform_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_vec(make_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_vec(make_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    drain_vectors();
    // x2.0 diagonal: just inside and just outside both limits
    load_matrix(uniform_matrix(32'h0002_0000, 32'h0000_0000));
    send_vec(make_vec(32'h3FFF_FFFF, 32'hC000_0000, 32'h4000_0000, 32'hBFFF_FFFF));
    send_vec(make_vec(32'h3FFF_FFFF, 32'hC000_0000, 32'h0000_0000, 32'h0000_0001));
    send_vec(make_vec(32'h4000_0000, 32'h3FFF_FFFF, 32'hC000_0000, 32'hC000_0000));
    drain_vectors();
  endtask

  task automatic test_floor_shift();
    // one-LSB coefficients: sums below one unit floor toward minus infinity
    load_matrix(uniform_matrix(32'h0000_0001, 32'h0000_0001));
    send_vec(make_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_vec(make_vec(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000));
    send_vec(make_vec(32'h0000_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000));
    drain_vectors();
    load_matrix(uniform_matrix(32'h0001_0000, 32'h0000_0000));
    send_vec(make_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF));
    send_vec(make_vec(32'hFFFF_8000, 32'h0000_8000, 32'h8000_0001, 32'h7FFF_FFFE));
    drain_vectors();
  endtask

  task automatic test_cfg_index_range();
    // indexes past the last register must leave the matrix untouched
    for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
    cfg_bus.valid <= 1'b0;
    @(negedge clk_i);
    repeat (3) send_vec(make_vec($urandom, $urandom, $urandom, $urandom));
    drain_vectors();
  endtask

  task automatic test_random_stream();
    reg_image_t m;
    for (int phase = 0; phase < 10; phase++) begin
      for (int i = 0; i < NUM_REGS; i++)
        m[i] = (phase % 4 == 3) ? {$urandom, $urandom} : {random_coef(), random_coef()};
      load_matrix(m);
      for (int n = 0; n < 145; n++) begin
        if (n % 30 == 0)
          no_gaps = ($urandom_range(0, 2) == 0);
        send_vec(make_vec(random_elem(), random_elem(), random_elem(), random_elem()));
      end
      drain_vectors();
    end
    no_gaps = 1'b0;
  endtask

  // result sink: random stall ahead of each word
  initial begin : sink_ready
    int stall;
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!res_bus.valid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    mvt_res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (transformed_vectors.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("%0t: result with none expected: %h", $realtime, res_bus.data);
      end else begin
        want = transformed_vectors.pop_front();
        if (res_bus.data.out_x !== want.out_x)
          note_mismatch("out_x", want.out_x, res_bus.data.out_x);
        if (res_bus.data.out_y !== want.out_y)
          note_mismatch("out_y", want.out_y, res_bus.data.out_y);
        if (res_bus.data.out_z !== want.out_z)
          note_mismatch("out_z", want.out_z, res_bus.data.out_z);
        if (res_bus.data.out_w !== want.out_w)
          note_mismatch("out_w", want.out_w, res_bus.data.out_w);
        if (res_bus.data.clipped !== want.clipped)
          note_mismatch("clipped", 32'(want.clipped), 32'(res_bus.data.clipped));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((vec_bus.valid && vec_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    no_gaps       = 1'b0;
    matrix_regs   = CFG_RESET;
    rst_ni        = 1'b0;
    vec_bus.valid = 1'b0;
    vec_bus.data  = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.wdata = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_matrix();
    test_saturation();
    test_floor_shift();
    test_cfg_index_range();
    test_random_stream();

    if (n_mismatch == 0 && transformed_vectors.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
